[hdl/capdu_pkg.sv]
// Shared types and constants for the command APDU serializer.
`default_nettype none
package capdu_pkg;

  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 32;
  localparam int CAP_W       = 17;
  localparam int LEN_W       = 16;
  localparam int MAX_BYTES   = 7;
  localparam int CNT_W       = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CAP_W-1:0] CAP_RESET    = 17'd65544;
  localparam logic [CAP_W-1:0] SHORT_LE_MAX = 17'd256;
  localparam logic [CAP_W-1:0] EXT_LE_MAX   = 17'd65536;
  localparam logic [LEN_W-1:0] SHORT_LC_MAX = 16'h00FF;
  localparam logic [7:0]       ZERO_BYTE    = 8'h00;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_BODY   = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_LE  = 2'd1;
  localparam logic [1:0] STATUS_NO_ROOM = 2'd2;

  // One queue entry: a run of 1..7 bytes to emit back to back.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      last;
    logic [1:0]                status;
    logic [CAP_W-1:0]          frame_len;
  } desc_t;

endpackage
`default_nettype wire

[hdl/capdu_front.sv]
// Front end: accepts header and body items, tracks the frame, queues byte runs.
`default_nettype none
module capdu_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [capdu_pkg::CAP_W-1:0]          cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [capdu_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [0:0]                           s_tuser,
  output logic                                 push,
  output capdu_pkg::desc_t                     push_desc,
  input  logic                                 full
);
  import capdu_pkg::*;

  logic [CAP_W-1:0] out_capacity;
  logic [LEN_W-1:0] body_left, body_left_next;
  logic [LEN_W-1:0] held_le, held_le_next;
  logic             held_want, held_want_next;
  logic             long_form, long_form_next;
  logic             dropping, dropping_next;
  logic [CAP_W-1:0] frame_total, frame_total_next;

  logic [7:0]       cla, ins, p1, p2, body_byte;
  logic [LEN_W-1:0] lc, body_dec;
  logic             want, has_body, ext, le_bad, no_room, take;
  logic [CAP_W-1:0] le, needed, extra;

  assign cla       = s_tdata[7:0];
  assign ins       = s_tdata[15:8];
  assign p1        = s_tdata[23:16];
  assign p2        = s_tdata[31:24];
  assign lc        = s_tdata[47:32];
  assign want      = s_tdata[48];
  assign le        = s_tdata[65:49];
  assign body_byte = s_tdata[73:66];

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign take      = s_tvalid && s_tready;

  assign has_body = (lc != '0);
  assign le_bad   = want && ((le == '0) || (le > EXT_LE_MAX));
  assign ext      = (lc > SHORT_LC_MAX) || (want && (le > SHORT_LE_MAX));
  assign body_dec = body_left - LEN_W'(1);

  always_comb begin
    case ({ext, has_body})
      2'b11:   extra = want ? 17'd9 : 17'd7;
      2'b10:   extra = want ? 17'd7 : 17'd4;
      2'b01:   extra = want ? 17'd6 : 17'd5;
      default: extra = want ? 17'd5 : 17'd4;
    endcase
  end

  assign needed  = (has_body ? {1'b0, lc} : '0) + extra;
  assign no_room = needed > out_capacity;

  always_comb begin
    body_left_next   = body_left;
    held_le_next     = held_le;
    held_want_next   = held_want;
    long_form_next   = long_form;
    dropping_next    = dropping;
    frame_total_next = frame_total;
    push             = 1'b0;
    push_desc        = '0;

    if (take && (s_tuser[0] == CMD_HEADER)) begin
      // A header always starts over; an open frame is abandoned.
      push             = 1'b1;
      body_left_next   = lc;
      held_le_next     = '0;
      held_want_next   = 1'b0;
      long_form_next   = 1'b0;
      dropping_next    = 1'b0;
      frame_total_next = '0;
      if (le_bad || no_room) begin
        dropping_next       = has_body;
        push_desc.bytes[0]  = ZERO_BYTE;
        push_desc.count     = CNT_W'(1);
        push_desc.last      = 1'b1;
        push_desc.status    = le_bad ? STATUS_BAD_LE : STATUS_NO_ROOM;
      end else begin
        held_want_next      = want;
        held_le_next        = want ? le[LEN_W-1:0] : '0;
        long_form_next      = ext;
        frame_total_next    = needed;
        push_desc.status    = STATUS_OK;
        push_desc.frame_len = needed;
        push_desc.bytes[0]  = cla;
        push_desc.bytes[1]  = ins;
        push_desc.bytes[2]  = p1;
        push_desc.bytes[3]  = p2;
        // Le of 256 (short) or 65536 (extended) encodes as zero: low bits do it.
        if (ext) begin
          push_desc.bytes[4] = ZERO_BYTE;
          if (has_body) begin
            push_desc.bytes[5] = lc[15:8];
            push_desc.bytes[6] = lc[7:0];
            push_desc.count    = CNT_W'(7);
            push_desc.last     = 1'b0;
          end else if (want) begin
            push_desc.bytes[5] = le[15:8];
            push_desc.bytes[6] = le[7:0];
            push_desc.count    = CNT_W'(7);
            push_desc.last     = 1'b1;
          end else begin
            push_desc.count    = CNT_W'(5);
            push_desc.last     = 1'b1;
          end
        end else if (has_body) begin
          push_desc.bytes[4] = lc[7:0];
          push_desc.count    = CNT_W'(5);
          push_desc.last     = 1'b0;
        end else if (want) begin
          push_desc.bytes[4] = le[7:0];
          push_desc.count    = CNT_W'(5);
          push_desc.last     = 1'b1;
        end else begin
          push_desc.count    = CNT_W'(4);
          push_desc.last     = 1'b1;
        end
      end
    end else if (take) begin
      if (body_left == '0) begin
        dropping_next = 1'b0;
      end else begin
        body_left_next = body_dec;
        if (dropping) begin
          if (body_dec == '0) begin
            dropping_next = 1'b0;
          end
        end else begin
          push                = 1'b1;
          push_desc.status    = STATUS_OK;
          push_desc.frame_len = frame_total;
          push_desc.bytes[0]  = body_byte;
          push_desc.count     = CNT_W'(1);
          push_desc.last      = (body_dec == '0);
          if ((body_dec == '0) && held_want) begin
            if (long_form) begin
              push_desc.bytes[1] = held_le[15:8];
              push_desc.bytes[2] = held_le[7:0];
              push_desc.count    = CNT_W'(3);
            end else begin
              push_desc.bytes[1] = held_le[7:0];
              push_desc.count    = CNT_W'(2);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
      body_left    <= '0;
      held_le      <= '0;
      held_want    <= 1'b0;
      long_form    <= 1'b0;
      dropping     <= 1'b0;
      frame_total  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        out_capacity <= cfg_data;
      end
      body_left   <= body_left_next;
      held_le     <= held_le_next;
      held_want   <= held_want_next;
      long_form   <= long_form_next;
      dropping    <= dropping_next;
      frame_total <= frame_total_next;
    end
  end

endmodule
`default_nettype wire

[hdl/capdu_queue.sv]
// Small register queue of byte runs between front end and serializer.
`default_nettype none
module capdu_queue #(
  parameter int DEPTH = capdu_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  capdu_pkg::desc_t push_desc,
  output logic             full,
  input  logic             pop,
  output capdu_pkg::desc_t pop_desc,
  output logic             empty
);
  import capdu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  desc_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] used;
  logic              do_push, do_pop;

  assign full     = (used == FULL_CNT);
  assign empty    = (used == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   used <= used + CNT_QW'(1);
        2'b01:   used <= used - CNT_QW'(1);
        default: used <= used;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/capdu_back.sv]
// Back end: walks each queued byte run and drives the registered output stream.
`default_nettype none
module capdu_back (
  input  logic                              clk,
  input  logic                              rst,
  input  capdu_pkg::desc_t                  head,
  input  logic                              empty,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [capdu_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [1:0]                        m_tuser,
  output logic                              m_tlast
);
  import capdu_pkg::*;

  logic [CNT_W-1:0] idx;
  logic             load, run_end;

  assign load    = !empty && (!m_tvalid || m_tready);
  assign run_end = (idx == head.count - CNT_W'(1));
  assign pop     = load && run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= run_end ? '0 : idx + CNT_W'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload register, no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata[7:0]            <= head.bytes[idx];
      m_tdata[24:8]           <= (run_end && head.last) ? head.frame_len : '0;
      m_tdata[OUT_DATA_W-1:25] <= '0;
      m_tuser                 <= head.status;
      m_tlast                 <= run_end && head.last;
    end
  end

endmodule
`default_nettype wire

[hdl/command_apdu_serializer.sv]
// Top level of the command APDU serializer: front end, run queue and byte serializer.
`default_nettype none
// Turns smart card command items into the byte stream of a command APDU in the
// short or extended form. A header item (s_tuser 0) yields CLA, INS, P1, P2 and
// the length bytes: 4, 5 or 7 output bytes. Body items (s_tuser 1) then pass one
// byte each; the last body byte is followed by the Le bytes (one in the short
// form, two in the extended form). An invalid Le or a frame larger than the
// capacity register gives a single error transaction (tlast set, status in
// tuser) and the frame's body items are swallowed. Rate: the serializer emits
// one byte per cycle while the reader is ready. Bytes per item: one per plain body
// byte, 2 or 3 for the final body byte with Le, 4 to 7 for a header, one for
// an error; a swallowed or stray body byte yields no output byte. The run
// queue between the front end and the serializer lets input keep flowing
// while a header's bytes drain, and the output register lets the next item be
// taken while a finished byte waits. The capacity register (reset 65544) may
// be written only while the block is idle; its channel is always ready.
module command_apdu_serializer #(
  parameter int QUEUE_DEPTH = capdu_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // capacity register write channel: out_capacity[16:0]
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [capdu_pkg::CAP_W-1:0]          cfg_data,
  // input items
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [7:0] class_byte, [15:8] instruction_byte, [23:16] param_one,
  // [31:24] param_two, [47:32] body_length, [48] want_response,
  // [65:49] expected_length, [73:66] body_byte, [79:74] zero
  input  logic [capdu_pkg::IN_DATA_W-1:0]      s_tdata,
  // [0] command (0 header, 1 body byte)
  input  logic [0:0]                           s_tuser,
  // output bytes
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [7:0] out_byte, [24:8] frame_length, [31:25] zero
  output logic [capdu_pkg::OUT_DATA_W-1:0]     m_tdata,
  // [1:0] status (0 ok, 1 invalid input, 2 buffer too small)
  output logic [1:0]                           m_tuser,
  // frame_end
  output logic                                 m_tlast
);
  import capdu_pkg::*;

  desc_t push_desc, head;
  logic  push, full, pop, empty;

  // Front end owns the frame state and the capacity check.
  capdu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_desc (push_desc),
    .full      (full)
  );

  // Runs of up to seven bytes wait here.
  capdu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .pop_desc  (head),
    .empty     (empty)
  );

  // One byte per cycle onto the output stream while the reader is ready.
  capdu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

[test/command_apdu_serializer_tb.sv]
// Self-checking testbench for the command APDU serializer: directed, random, capacity sweep.
`timescale 1ns / 1ps

module command_apdu_serializer_tb;
  import capdu_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  // Covers the run queue, the output register and a stalled reader.
  localparam int DRAIN_CYCLES = 24;

  // One input transaction, fields as the block sees them.
  typedef struct {
    logic             cmd;
    logic [7:0]       cla;
    logic [7:0]       ins;
    logic [7:0]       p1;
    logic [7:0]       p2;
    logic [LEN_W-1:0] lc;
    logic             want;
    logic [CAP_W-1:0] le;
    logic [7:0]       body;
  } apdu_item_t;

  // One output transaction.
  typedef struct {
    logic [7:0]       data;
    logic             last;
    logic [1:0]       status;
    logic [CAP_W-1:0] frame_len;
  } apdu_byte_t;

  // Reader stall patterns.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_CADENCE,
    READY_SLOW
  } ready_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  command_apdu_serializer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  apdu_item_t pending[$];         // items waiting for the driver
  apdu_byte_t expected_bytes[$];  // predicted output transactions, oldest first
  int         mismatches = 0;

  // Predictor state, mirrors the block from reset on.
  logic [CAP_W-1:0] capacity_reg   = CAP_RESET;
  logic [LEN_W-1:0] frame_body_left = '0;
  logic [CAP_W-1:0] frame_le       = '0;
  logic             frame_want     = 1'b0;
  logic             frame_extended = 1'b0;
  logic             frame_dropping = 1'b0;
  logic [CAP_W-1:0] frame_sent     = '0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b, input logic last);
    apdu_byte_t e;
    frame_sent  = frame_sent + 1'b1;
    e.data      = b;
    e.last      = last;
    e.status    = STATUS_OK;
    e.frame_len = last ? frame_sent : '0;
    expected_bytes.push_back(e);
  endfunction

  function automatic void push_error(input logic [1:0] code);
    apdu_byte_t e;
    e.data      = ZERO_BYTE;
    e.last      = 1'b1;
    e.status    = code;
    e.frame_len = '0;
    expected_bytes.push_back(e);
  endfunction

  // Le trailer: 256 goes out as 00 in the short form, 65536 as 00 00 in the long one.
  function automatic void push_le();
    logic [CAP_W-1:0] le;
    if (frame_extended) begin
      le = (frame_le >= EXT_LE_MAX) ? '0 : frame_le;
      push_byte(le[15:8], 1'b0);
      push_byte(le[7:0], 1'b1);
    end else begin
      le = (frame_le == SHORT_LE_MAX) ? '0 : frame_le;
      push_byte(le[7:0], 1'b1);
    end
  endfunction

  function automatic void encode_apdu_item(input apdu_item_t it);
    logic has_body;
    logic ext;
    int   needed;
    if (it.cmd == CMD_HEADER) begin
      has_body = (it.lc != '0);
      // a header always abandons whatever frame is open
      frame_body_left = '0;
      frame_dropping  = 1'b0;
      frame_want      = 1'b0;
      frame_le        = '0;
      frame_extended  = 1'b0;
      frame_sent      = '0;
      if (it.want && (it.le == '0 || it.le > EXT_LE_MAX)) begin
        frame_body_left = it.lc;
        frame_dropping  = has_body;
        push_error(STATUS_BAD_LE);
        return;
      end
      ext = (it.lc > SHORT_LC_MAX) || (it.want && it.le > SHORT_LE_MAX);
      needed = 4;
      if (ext)
        needed += has_body ? (3 + int'(it.lc) + (it.want ? 2 : 0)) : (it.want ? 3 : 0);
      else
        needed += (has_body ? 1 + int'(it.lc) : 0) + (it.want ? 1 : 0);
      if (needed > int'(capacity_reg)) begin
        frame_body_left = it.lc;
        frame_dropping  = has_body;
        push_error(STATUS_NO_ROOM);
        return;
      end
      frame_want      = it.want;
      frame_le        = it.want ? it.le : '0;
      frame_extended  = ext;
      frame_body_left = it.lc;
      push_byte(it.cla, 1'b0);
      push_byte(it.ins, 1'b0);
      push_byte(it.p1, 1'b0);
      push_byte(it.p2, !has_body && !it.want && !ext);
      if (ext) begin
        push_byte(ZERO_BYTE, !has_body && !it.want);
        if (has_body) begin
          push_byte(it.lc[15:8], 1'b0);
          push_byte(it.lc[7:0], 1'b0);
        end else if (it.want) begin
          push_le();
        end
      end else if (has_body) begin
        push_byte(it.lc[7:0], 1'b0);
      end else if (it.want) begin
        push_le();
      end
      return;
    end
    // body byte
    if (frame_body_left == '0) begin
      frame_dropping = 1'b0;  // stray byte, swallowed
      return;
    end
    frame_body_left = frame_body_left - 1'b1;
    if (frame_dropping) begin
      if (frame_body_left == '0)
        frame_dropping = 1'b0;
      return;
    end
    push_byte(it.body, frame_body_left == '0 && !frame_want);
    if (frame_body_left == '0 && frame_want)
      push_le();
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders: unused fields carry random junk
  // ---------------------------------------------------------------------------

  function automatic apdu_item_t header_item(input logic [7:0] cla, input logic [7:0] ins,
                                             input logic [7:0] p1, input logic [7:0] p2,
                                             input logic [LEN_W-1:0] lc, input logic want,
                                             input logic [CAP_W-1:0] le);
    apdu_item_t it;
    it.cmd  = CMD_HEADER;
    it.cla  = cla;
    it.ins  = ins;
    it.p1   = p1;
    it.p2   = p2;
    it.lc   = lc;
    it.want = want;
    it.le   = le;
    it.body = 8'($urandom);
    return it;
  endfunction

  function automatic apdu_item_t body_item(input logic [7:0] b);
    apdu_item_t it;
    it.cmd  = CMD_BODY;
    it.cla  = 8'($urandom);
    it.ins  = 8'($urandom);
    it.p1   = 8'($urandom);
    it.p2   = 8'($urandom);
    it.lc   = LEN_W'($urandom);
    it.want = 1'($urandom);
    it.le   = CAP_W'($urandom);
    it.body = b;
    return it;
  endfunction

  // Queues one random frame (mostly well formed, some truncated, some stray noise).
  // A body longer than the room left in the phase is cut short.
  // Returns the number of items queued.
  function automatic int add_random_frame(input int room);
    int               shape;
    int               pick;
    int               sent;
    logic [LEN_W-1:0] lc;
    logic [CAP_W-1:0] le;
    logic             want;
    shape = $urandom_range(0, 99);
    if (shape < 6) begin
      sent = $urandom_range(1, 3);
      repeat (sent) pending.push_back(body_item(8'($urandom)));
      return sent;
    end
    pick = $urandom_range(0, 199);
    if (pick < 50)       lc = '0;
    else if (pick < 160) lc = LEN_W'($urandom_range(1, 6));
    else if (pick < 194) lc = LEN_W'($urandom_range(7, 40));
    else if (pick < 197) lc = LEN_W'(255);
    else                 lc = LEN_W'($urandom_range(256, 258));
    want = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10)      le = '0;
    else if (pick < 20) le = CAP_W'(1);
    else if (pick < 45) le = CAP_W'($urandom_range(2, 255));
    else if (pick < 55) le = SHORT_LE_MAX;
    else if (pick < 65) le = SHORT_LE_MAX + 1'b1;
    else if (pick < 78) le = CAP_W'($urandom_range(258, 65535));
    else if (pick < 88) le = EXT_LE_MAX;
    else                le = CAP_W'($urandom);
    pending.push_back(header_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                  lc, want, le));
    sent = int'(lc);
    // truncated body: the next header abandons the frame
    if (shape < 14 && lc != '0)
      sent = $urandom_range(0, int'(lc) - 1);
    if (sent >= room)
      sent = room - 1;
    for (int i = 0; i < sent; i++)
      pending.push_back(body_item(8'($urandom)));
    return sent + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------

  apdu_item_t drv_item;
  int         burst_left;
  int         gap_left;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tuser    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // transaction accepted at this edge: predict its results
      if (s_tvalid && s_tready)
        encode_apdu_item(drv_item);
      if (!s_tvalid || s_tready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            3:       gap_left = $urandom_range(20, 40);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
        if (gap_left > 0 || pending.size() == 0) begin
          if (gap_left > 0)
            gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          drv_item = pending.pop_front();
          burst_left--;
          s_tvalid <= 1'b1;
          s_tuser  <= drv_item.cmd;
          s_tdata  <= {6'd0, drv_item.body, drv_item.le, drv_item.want, drv_item.lc,
                       drv_item.p2, drv_item.p1, drv_item.ins, drv_item.cla};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: reader stall pattern and result check
  // ---------------------------------------------------------------------------

  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left  = 0;
  logic [2:0]  ready_tick = '0;

  always @(posedge clk) begin
    apdu_byte_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transaction: out_byte %0h status %0d",
                 m_tdata[7:0], m_tuser);
          mismatches++;
        end else begin
          e = expected_bytes.pop_front();
          if (m_tdata[7:0] !== e.data) begin
            $error("out_byte: expected %0h, actual %0h", e.data, m_tdata[7:0]);
            mismatches++;
          end
          if (m_tlast !== e.last) begin
            $error("frame_end: expected %0d, actual %0d", e.last, m_tlast);
            mismatches++;
          end
          if (m_tuser !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, m_tuser);
            mismatches++;
          end
          if (m_tdata[24:8] !== e.frame_len) begin
            $error("frame_length: expected %0d, actual %0d", e.frame_len, m_tdata[24:8]);
            mismatches++;
          end
        end
      end
      // switch stall pattern every so often
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      ready_tick = ready_tick + 1'b1;
      case (ready_mode)
        READY_ALWAYS:  m_tready <= 1'b1;
        READY_COIN:    m_tready <= ($urandom_range(0, 2) != 0);
        READY_CADENCE: m_tready <= (ready_tick != 3'd2 && ready_tick != 3'd5);
        default:       m_tready <= (ready_tick == 3'd0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Timeout
  // ---------------------------------------------------------------------------

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  // Waits until every queued item went in and every predicted byte came out,
  // then lets the pipeline settle (swallowed bytes leave no trace).
  task automatic wait_until_drained();
    do @(posedge clk);
    while (pending.size() != 0 || s_tvalid || expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    capacity_reg = value;
    cfg_valid <= 1'b0;
  endtask

  logic [CAP_W-1:0] cap_plan[10];
  int               budget;
  int               added;

  initial begin
    // low, boundary, reset-value and all-ones capacities, plus one random pick
    cap_plan = '{17'd0, 17'd4, 17'd5, 17'd6, 17'd7, 17'd12, 17'd300, 17'd65544,
                 17'h1FFFF, 17'd0};
    cap_plan[9] = CAP_W'($urandom_range(8, 300));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the reset capacity.
    // header only, all bits set: frame ends on P2
    pending.push_back(header_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 1'b0, 17'h1FFFF));
    // short Le of 256 goes out as 00
    pending.push_back(header_item(8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b1, SHORT_LE_MAX));
    // short Le of 255
    pending.push_back(header_item(8'h80, 8'hB0, 8'h01, 8'h02, 16'd0, 1'b1, 17'd255));
    // Le of 65536 forces the long form: 00 00 00
    pending.push_back(header_item(8'h00, 8'hCA, 8'h9F, 8'h7F, 16'd0, 1'b1, EXT_LE_MAX));
    // Le of 0 requested: invalid input
    pending.push_back(header_item(8'h00, 8'hA4, 8'h04, 8'h0C, 16'd0, 1'b1, 17'd0));
    // short body, Le field ignored because no response wanted
    pending.push_back(header_item(8'h0C, 8'hD6, 8'h00, 8'h00, 16'd2, 1'b0, 17'h1FFFF));
    pending.push_back(body_item(8'h00));
    pending.push_back(body_item(8'hFF));
    // Le of 257 with one body byte: long form, Le follows the body
    pending.push_back(header_item(8'h00, 8'h2A, 8'h9E, 8'h9A, 16'd1, 1'b1, 17'd257));
    pending.push_back(body_item(8'hA5));
    // Le above 65536: rejected, its body swallowed
    pending.push_back(header_item(8'h00, 8'h88, 8'h00, 8'h00, 16'd3, 1'b1, 17'd65537));
    pending.push_back(body_item(8'h11));
    pending.push_back(body_item(8'h22));
    pending.push_back(body_item(8'h33));
    // stray body byte with no frame open
    pending.push_back(body_item(8'h5A));
    // largest body with largest Le exactly fills the reset capacity; abandoned early
    pending.push_back(header_item(8'h00, 8'hD6, 8'h00, 8'h00, 16'hFFFF, 1'b1, EXT_LE_MAX));
    pending.push_back(body_item(8'h01));
    pending.push_back(body_item(8'h02));
    // header in the middle of a body: previous frame dropped, this one truncated too
    pending.push_back(header_item(8'h00, 8'h82, 8'h00, 8'h00, 16'd4, 1'b1, 17'd1));
    pending.push_back(body_item(8'hC3));
    // short body with Le of 1
    pending.push_back(header_item(8'h00, 8'hB2, 8'h01, 8'h04, 16'd1, 1'b1, 17'd1));
    pending.push_back(body_item(8'h3C));

    // Random frames, one capacity setting per phase.
    foreach (cap_plan[i]) begin
      wait_until_drained();
      write_capacity(cap_plan[i]);
      budget = (cap_plan[i] == 17'd0 || cap_plan[i] == 17'h1FFFF) ? 22 : 42;
      added = 0;
      while (added < budget)
        added += add_random_frame(budget - added);
    end

    wait_until_drained();
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
